// ===== sv/sync_len_checksum_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length/checksum frame receiver
// Shared shorthand for concurrent assertions on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SYNC_LEN_CHECKSUM_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LEN_CHECKSUM_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLCFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver assertion failed");

// Next-cycle implication, checked outside reset.
`define SLCFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");

`endif

// ===== sv/slcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slcfr_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slcfr_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int OUT_DATA_W = 24;

  localparam logic [7:0] SYNC_FIRST  = 8'hED;
  localparam logic [7:0] SYNC_SECOND = 8'h8C;
  localparam logic [7:0] END_MARK    = 8'h8D;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;

  typedef enum logic [2:0] {
    FS_HUNT0 = 3'd0,
    FS_HUNT1 = 3'd1,
    FS_ADDR  = 3'd2,
    FS_LEN   = 3'd3,
    FS_DATA  = 3'd4,
    FS_SUM   = 3'd5,
    FS_END   = 3'd6
  } frame_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_SHOW
  } emit_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic busy;
    logic q_full;
  } emit_status_t;

endpackage

`default_nettype wire

// ===== sv/slcfr_front.sv =====
// ----------------------------------------------------------------------------
// slcfr_front
// Byte parser: sync hunt, header, payload capture, checksum and end check.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,
  input  wire logic                        cfg_wr_en,
  input  wire logic [7:0]                  cfg_wr_data,
  input  wire slcfr_pkg::emit_status_t     emit_status,
  output slcfr_pkg::store_wr_t             store_wr,
  output logic                             cmd_push,
  output logic [slcfr_pkg::CNT_W-1:0]      cmd_count
);
  import slcfr_pkg::*;

  frame_state_t     state_r, state_nxt;
  logic [7:0]       dev_addr_r;
  logic [7:0]       frame_addr_r, frame_addr_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic             take;
  logic [7:0]       b;
  logic [7:0]       sum_add;

  assign b       = in_tdata & BYTE_MASK;
  assign sum_add = sum_r + b;

  // The payload store is shared with the drain side, so payload bytes wait
  // while an earlier frame is still queued or being sent.
  always_comb begin
    in_tready = 1'b1;
    if (state_r == FS_DATA && emit_status.busy) begin
      in_tready = 1'b0;
    end
    if (state_r == FS_END && emit_status.q_full) begin
      in_tready = 1'b0;
    end
  end

  assign take = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    frame_addr_nxt = frame_addr_r;
    sum_nxt        = sum_r;
    remain_nxt     = remain_r;
    stored_nxt     = stored_r;
    store_wr.en    = 1'b0;
    store_wr.addr  = stored_r[ADDR_W-1:0];
    store_wr.data  = b;
    cmd_push       = 1'b0;
    cmd_count      = stored_r;
    if (take) begin
      case (state_r)
        FS_HUNT0: begin
          if (b == SYNC_FIRST) begin
            state_nxt  = FS_HUNT1;
            stored_nxt = '0;
          end
        end
        FS_HUNT1: begin
          state_nxt = (b == SYNC_SECOND) ? FS_ADDR : FS_HUNT0;
        end
        FS_ADDR: begin
          frame_addr_nxt = b;
          sum_nxt        = b;
          state_nxt      = FS_LEN;
        end
        FS_LEN: begin
          if (b == 8'd0 || {1'b0, b} > 9'(PAYLOAD_DEPTH)) begin
            state_nxt = FS_HUNT0;
          end else begin
            sum_nxt    = sum_add;
            remain_nxt = b[CNT_W-1:0];
            state_nxt  = FS_DATA;
          end
        end
        FS_DATA: begin
          if (stored_r < CNT_W'(PAYLOAD_DEPTH)) begin
            store_wr.en = 1'b1;
            stored_nxt  = stored_r + 1'b1;
          end
          sum_nxt    = sum_add;
          remain_nxt = remain_r - 1'b1;
          if (remain_nxt == '0) begin
            state_nxt = FS_SUM;
          end
        end
        FS_SUM: begin
          sum_nxt   = sum_add;
          state_nxt = (sum_add == 8'd0) ? FS_END : FS_HUNT0;
        end
        FS_END: begin
          if (b == END_MARK && frame_addr_r == dev_addr_r) begin
            cmd_push = 1'b1;
          end
          state_nxt = FS_HUNT0;
        end
        default: begin
          state_nxt = FS_HUNT0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FS_HUNT0;
      dev_addr_r   <= '0;
      frame_addr_r <= '0;
      sum_r        <= '0;
      remain_r     <= '0;
      stored_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      frame_addr_r <= frame_addr_nxt;
      sum_r        <= sum_nxt;
      remain_r     <= remain_nxt;
      stored_r     <= stored_nxt;
      if (cfg_wr_en) begin
        dev_addr_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/slcfr_cmdq.sv =====
// ----------------------------------------------------------------------------
// slcfr_cmdq
// One-entry queue of accepted-frame commands between parser and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_cmdq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [slcfr_pkg::CNT_W-1:0] push_count,
  input  wire logic                        pop,
  output logic                             q_valid,
  output logic [slcfr_pkg::CNT_W-1:0]      q_count
);
  import slcfr_pkg::*;

  logic             valid_r;
  logic [CNT_W-1:0] count_r;

  assign q_valid = valid_r;
  assign q_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      count_r <= push_count;
    end
  end

endmodule

`default_nettype wire

// ===== sv/slcfr_back.sv =====
// ----------------------------------------------------------------------------
// slcfr_back
// Payload store and drain: sends a stored payload as a run of result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire slcfr_pkg::store_wr_t             store_wr,
  input  wire logic                             q_valid,
  input  wire logic [slcfr_pkg::CNT_W-1:0]      q_count,
  output logic                                  q_pop,
  output logic                                  active,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [slcfr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                  out_tlast
);
  import slcfr_pkg::*;

  logic [7:0]       mem [PAYLOAD_DEPTH];
  logic [7:0]       rd_data_r;
  emit_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r;
  logic             is_last;
  logic             rd_en;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  assign is_last = (CNT_W'(idx_r) + 1'b1) == count_r;
  assign active  = (state_r != EM_IDLE);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      EM_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          idx_nxt   = '0;
          state_nxt = EM_READ;
        end
      end
      EM_READ: begin
        rd_en     = 1'b1;
        state_nxt = EM_SHOW;
      end
      EM_SHOW: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (is_last) begin
            state_nxt = EM_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = EM_READ;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (q_pop) begin
      count_r <= q_count;
    end
  end

  assign out_tdata = {3'b000, count_r, idx_r, rd_data_r};
  assign out_tlast = is_last;

endmodule

`default_nettype wire

// ===== sv/sync_len_checksum_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sync_len_checksum_frame_receiver
// Serial frame receiver with sync bytes, length, sum checksum and end mark.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the in_ stream, one byte per transfer. The
// parser hunts for the sync pair 0xED 0x8C, takes an address and a length
// (1 to PAYLOAD_DEPTH), stores the payload, checks that the byte sum of
// address, length, payload and checksum is zero, then requires the end byte
// 0x8D and an address equal to the value last written on the cfg_ port.
// A good frame is sent on the out_ stream as one transfer per payload byte,
// with out_tlast on the final one. Bad frames produce nothing.
// Throughput: the parser takes one byte per cycle while in_tready is high.
// The end byte queues a command; the drain pops it and shows each result from
// a registered read of the payload store, reading the next only once the
// current result is taken. While a finished frame is queued or draining, the
// parser keeps hunting and reading headers, but holds in_tready low on payload
// bytes, as the store has one copy, and on the end byte while a command waits.
// Reset (rst_n low, synchronous) returns the parser to hunting, empties the
// command queue, stops the drain and clears the device address to zero.
// If the receiver stalls, the current result holds on out_tdata.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_len_checksum_frame_receiver (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,
  // out_tdata: [7:0] payload_byte, [13:8] byte_index, [20:14] payload_length,
  // [23:21] zero
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [slcfr_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                    out_tlast,
  // Device address register.
  input  wire logic                               cfg_wr_en,
  input  wire logic [7:0]                         cfg_wr_data
);
  import slcfr_pkg::*;

  store_wr_t        store_wr;
  emit_status_t     emit_status;
  logic             cmd_push;
  logic [CNT_W-1:0] cmd_count;
  logic             q_valid;
  logic [CNT_W-1:0] q_count;
  logic             q_pop;
  logic             back_active;

  // The parser sees the drain as busy while a command waits or a run is going.
  assign emit_status.busy   = q_valid || back_active;
  assign emit_status.q_full = q_valid;

  slcfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .emit_status (emit_status),
    .store_wr    (store_wr),
    .cmd_push    (cmd_push),
    .cmd_count   (cmd_count)
  );

  slcfr_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_count (cmd_count),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_count    (q_count)
  );

  slcfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .store_wr   (store_wr),
    .q_valid    (q_valid),
    .q_count    (q_count),
    .q_pop      (q_pop),
    .active     (back_active),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/slcfr_checker.sv =====
// ----------------------------------------------------------------------------
// slcfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_len_checksum_frame_receiver_macros.svh"

module slcfr_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [slcfr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                          out_tlast
);
  import slcfr_pkg::*;

  logic [CNT_W-1:0] len_f;
  logic [IDX_W-1:0] idx_f;

  assign len_f = out_tdata[20:14];
  assign idx_f = out_tdata[13:8];

  // A stalled result holds its value.
  `SLCFR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The marked byte is the one at position length minus one.
  `SLCFR_ASSERT_IMP(a_last_pos, out_tvalid && out_tlast, len_f == (CNT_W'(idx_f) + 7'd1))

  // Every result carries a length the store can hold and an index inside it.
  `SLCFR_ASSERT_IMP(a_len_range, out_tvalid, len_f != 7'd0 && len_f <= CNT_W'(PAYLOAD_DEPTH))
  `SLCFR_ASSERT_IMP(a_idx_range, out_tvalid, CNT_W'(idx_f) < len_f)

endmodule

bind sync_len_checksum_frame_receiver slcfr_checker u_slcfr_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the sync/length/checksum frame receiver
// Sends random and hand-built frames, predicts the payload transfers, checks.
// ----------------------------------------------------------------------------
// Bytes go in on the in_ stream and payload transfers come back on the out_
// stream. A small scoreboard class follows the frame parser byte by byte and
// queues the payload transfers that each accepted byte should cause. Every
// transfer seen on the out_ stream is checked against the oldest one queued.
// The device address is changed between phases, only once the parser is back
// to hunting and every queued transfer has arrived.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slcfr_pkg::*;

  // One payload transfer as the out_ stream should present it.
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic [CNT_W-1:0] payload_length;
    logic             last;
  } payload_xfer_t;

  // Ways a generated frame can be spoiled. A bad length is chosen by the
  // caller through the length byte itself.
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SYNC,
    FRAME_BAD_SUM,
    FRAME_BAD_END,
    FRAME_FOREIGN
  } frame_flaw_t;

  // Follows the frame parser and holds the payload transfers still owed.
  class payload_tracker;
    frame_state_t  state;
    logic [7:0]    own_addr;
    logic [7:0]    frame_addr;
    logic [7:0]    sum;
    logic [6:0]    remaining;
    logic [6:0]    stored;
    logic [7:0]    store [PAYLOAD_DEPTH];
    payload_xfer_t expected [$];
    int            mismatches;

    function new();
      state      = FS_HUNT0;
      own_addr   = 8'h00;
      frame_addr = 8'h00;
      sum        = 8'h00;
      remaining  = 7'd0;
      stored     = 7'd0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s", $time, msg);
    endfunction

    // Advances the parser by one accepted byte.
    function void take_rx_byte(logic [7:0] b);
      payload_xfer_t xfer;
      case (state)
        FS_HUNT0: begin
          if (b == SYNC_FIRST) begin
            state  = FS_HUNT1;
            stored = 7'd0;
          end
        end
        FS_HUNT1: begin
          // A wrong second sync byte is never taken as a fresh first one.
          state = (b == SYNC_SECOND) ? FS_ADDR : FS_HUNT0;
        end
        FS_ADDR: begin
          frame_addr = b;
          sum        = b;
          state      = FS_LEN;
        end
        FS_LEN: begin
          if (b == 8'd0 || b > PAYLOAD_DEPTH) begin
            state = FS_HUNT0;
          end else begin
            sum       = sum + b;
            remaining = b[6:0];
            state     = FS_DATA;
          end
        end
        FS_DATA: begin
          if (stored < PAYLOAD_DEPTH) begin
            store[stored] = b;
            stored        = stored + 7'd1;
          end
          sum       = sum + b;
          remaining = remaining - 7'd1;
          if (remaining == 7'd0)
            state = FS_SUM;
        end
        FS_SUM: begin
          sum   = sum + b;
          state = (sum == 8'd0) ? FS_END : FS_HUNT0;
        end
        FS_END: begin
          if (b == END_MARK && frame_addr == own_addr) begin
            for (int k = 0; k < stored; k++) begin
              xfer.payload_byte   = store[k];
              xfer.byte_index     = k[IDX_W-1:0];
              xfer.payload_length = stored;
              xfer.last           = (k + 1 == stored);
              expected.push_back(xfer);
            end
          end
          state = FS_HUNT0;
        end
        default: begin
          state = FS_HUNT0;
        end
      endcase
    endfunction

    // Checks one payload transfer against the oldest one owed.
    function void check_payload_transfer(logic [OUT_DATA_W-1:0] data, logic tlast);
      payload_xfer_t want;
      if (expected.size() == 0) begin
        flag($sformatf("unexpected transfer: tdata=%h tlast=%b", data, tlast));
        return;
      end
      want = expected.pop_front();
      if (data[7:0] !== want.payload_byte)
        flag($sformatf("payload_byte: expected %h, got %h", want.payload_byte, data[7:0]));
      if (data[13:8] !== want.byte_index)
        flag($sformatf("byte_index: expected %0d, got %0d", want.byte_index, data[13:8]));
      if (data[20:14] !== want.payload_length)
        flag($sformatf("payload_length: expected %0d, got %0d",
                       want.payload_length, data[20:14]));
      if (tlast !== want.last)
        flag($sformatf("last: expected %b, got %b", want.last, tlast));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [7:0]            cfg_wr_data;

  payload_tracker tracker = new();

  // When set, neither side idles: this gives a long stretch at full rate.
  bit         steady = 1'b0;
  int         rx_sent = 0;
  logic [7:0] device_addr = 8'h00;

  sync_len_checksum_frame_receiver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The result side stalls about a third of the time unless running steady.
  // Stalls are drawn every cycle, so they land on every phase of the drain.
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 33);
  end

  // Every payload transfer is checked at the edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_payload_transfer(out_tdata, out_tlast);
  end

  // Sends one byte. Drives at the falling edge and returns at the rising edge
  // of the transfer, so the next call drives on the following falling edge
  // and in_tvalid is never lowered and raised within one time step.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tracker.take_rx_byte(b);
    rx_sent++;
  endtask

  // Builds one frame. The payload is sent only when the length byte is legal;
  // fill below zero means random payload bytes.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] len_byte,
                            input frame_flaw_t flaw, input int fill);
    logic [7:0] second;
    logic [7:0] data;
    logic [7:0] sum_acc;
    logic [7:0] chk;
    logic [7:0] end_byte;
    int         n;
    n = (len_byte >= 1 && len_byte <= PAYLOAD_DEPTH) ? int'(len_byte) : 0;
    send_byte(SYNC_FIRST);
    second = SYNC_SECOND;
    if (flaw == FRAME_BAD_SYNC) begin
      // Half of the broken syncs repeat the first sync byte.
      second = $urandom_range(1) ? SYNC_FIRST : 8'($urandom_range(255));
      if (second == SYNC_SECOND)
        second = 8'h00;
    end
    send_byte(second);
    send_byte(addr);
    send_byte(len_byte);
    sum_acc = addr + len_byte;
    if (n == 0)
      return;
    for (int k = 0; k < n; k++) begin
      data = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
      send_byte(data);
      sum_acc = sum_acc + data;
    end
    chk = -sum_acc;
    if (flaw == FRAME_BAD_SUM)
      chk = chk + 8'($urandom_range(1, 255));
    send_byte(chk);
    end_byte = END_MARK;
    if (flaw == FRAME_BAD_END) begin
      end_byte = 8'($urandom_range(255));
      if (end_byte == END_MARK)
        end_byte = ~END_MARK;
    end
    send_byte(end_byte);
  endtask

  // Mostly short payloads, some mid-sized, a few at the full store size.
  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60)
      return 8'($urandom_range(1, 6));
    else if (r < 90)
      return 8'($urandom_range(7, PAYLOAD_DEPTH - 1));
    else
      return 8'(PAYLOAD_DEPTH);
  endfunction

  // Random frames, mostly well formed, until target more bytes are sent.
  task automatic run_traffic(input int target);
    int          first;
    int          r;
    logic [7:0]  len_byte;
    logic [7:0]  addr;
    frame_flaw_t flaw;
    first = rx_sent;
    while (rx_sent - first < target) begin
      // Line noise between frames.
      if ($urandom_range(99) < 20)
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)));
      r        = $urandom_range(99);
      flaw     = FRAME_GOOD;
      len_byte = pick_length();
      addr     = device_addr;
      if (r >= 94)
        len_byte = $urandom_range(1) ? 8'd0 : 8'($urandom_range(PAYLOAD_DEPTH + 1, 255));
      else if (r >= 88)
        flaw = FRAME_FOREIGN;
      else if (r >= 81)
        flaw = FRAME_BAD_END;
      else if (r >= 73)
        flaw = FRAME_BAD_SUM;
      else if (r >= 65)
        flaw = FRAME_BAD_SYNC;
      if (flaw == FRAME_FOREIGN)
        addr = device_addr ^ 8'($urandom_range(1, 255));
      send_frame(addr, len_byte, flaw, -1);
    end
  endtask

  // Holds the sender off until every owed transfer has come, then lets the
  // parser settle before returning.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Returns the parser to hunting with zero bytes, drains, then writes the
  // new device address.
  task automatic change_address(input logic [7:0] addr);
    while (tracker.state != FS_HUNT0)
      send_byte(8'h00);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    tracker.own_addr = addr;
    device_addr      = addr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hard limit on the run in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'h00;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Hand-built cases at the reset address of zero. A one-byte payload of
    // all ones goes through.
    send_frame(8'h00, 8'd1, FRAME_GOOD, 8'hFF);
    // A repeated first sync byte does not resync, so the sync byte that
    // follows it is ignored as well.
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    // Zero length and a length just above the store size drop the frame.
    send_frame(8'h00, 8'd0, FRAME_GOOD, -1);
    send_frame(8'h00, 8'(PAYLOAD_DEPTH + 1), FRAME_GOOD, -1);
    // Bad checksum, wrong end byte and a foreign address give nothing.
    send_frame(8'h00, 8'd1, FRAME_BAD_SUM, 8'h00);
    send_frame(8'h00, 8'd1, FRAME_BAD_END, 8'h00);
    send_frame(8'hFF, 8'd1, FRAME_GOOD, 8'h00);

    // Top address, with a pause halfway through until the drain is done.
    change_address(8'hFF);
    run_traffic(65);
    wait_drained();
    run_traffic(65);

    // Random address, with neither side idling.
    change_address(8'($urandom_range(1, 254)));
    steady = 1'b1;
    run_traffic(130);
    steady = 1'b0;

    // Back to address zero.
    change_address(8'h00);
    run_traffic(130);

    wait_drained();
    repeat (16) @(negedge clk);
    if (tracker.expected.size() != 0)
      tracker.flag($sformatf("%0d payload transfers never arrived",
                             tracker.expected.size()));
    if (tracker.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
